>>> rtl/btp_pkg.sv
`default_nettype none

package btp_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned ID_W     = 15;
  localparam int unsigned DEV_W    = 16;
  localparam int unsigned IDR_W    = 17;
  localparam int unsigned DEVR_W   = 18;
  localparam int unsigned FRAC_W   = 16;
  // Dividend is tally * 2^16 plus half the divisor, which can carry into bit 32.
  localparam int unsigned DVD_W    = 33;
  localparam int unsigned QUO_W    = 18;
  localparam int unsigned CNT_W    = 6;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [ID_W-1:0]  ID_MAX  = '1;
  localparam logic [DEV_W-1:0] DEV_MAX = '1;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  typedef struct packed {
    logic [3:0] ids;
    logic [4:0] dev;
  } score_t;

  // Scores the eight tokens of one adjacent byte pair.
  function automatic score_t pair_score(input logic [7:0] a, input logic [7:0] b);
    score_t     s;
    logic [1:0] sa;
    logic [1:0] sb;
    logic [1:0] xa;
    logic [1:0] xb;
    logic [1:0] ds;
    logic [1:0] dd;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      sa = {1'b0, a[2*k+1]} + {1'b0, a[2*k]};
      sb = {1'b0, b[2*k+1]} + {1'b0, b[2*k]};
      xa = {1'b0, a[2*k+1]} + {1'b0, b[2*k]};
      xb = {1'b0, a[2*k]} + {1'b0, b[2*k+1]};
      ds = (sa > sb) ? sa - sb : sb - sa;
      dd = (xa > xb) ? xa - xb : xb - xa;
      s.ids = s.ids + 4'(ds == 2'd0) + 4'(dd == 2'd0);
      s.dev = s.dev + 5'(ds) + 5'(dd);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/btp_ctrl.sv
`default_nettype none

module btp_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              last_byte,
  output logic             out_valid,
  input  wire              out_ready,
  output btp_pkg::cmd_t    cmd,
  input  wire btp_pkg::status_t status
);

  btp_pkg::state_t state;
  btp_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btp_pkg::ST_ACCEPT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      btp_pkg::ST_ACCEPT: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && last_byte) begin
          state_next = btp_pkg::ST_PREP;
        end
      end
      btp_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = btp_pkg::ST_DIVIDE;
      end
      btp_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = btp_pkg::ST_FINISH;
        end
      end
      btp_pkg::ST_FINISH: begin
        // The output register may still hold the previous region's result.
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = btp_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_next = btp_pkg::ST_ACCEPT;
      end
    endcase

    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/btp_datapath.sv
`default_nettype none

module btp_datapath #(
  parameter int unsigned SAMPLE_LIMIT = 4096
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire btp_pkg::cmd_t                cmd,
  output btp_pkg::status_t                  status,
  input  wire  [7:0]                        data_byte,
  input  wire                               last_byte,
  input  wire  [btp_pkg::ADDR_W-1:0]        region_address,
  output logic [btp_pkg::ADDR_W-1:0]        out_address,
  output logic [btp_pkg::LEN_W-1:0]         region_length,
  output logic [btp_pkg::ID_W-1:0]          identity_count,
  output logic [btp_pkg::DEV_W-1:0]         deviation_sum,
  output logic [btp_pkg::IDR_W-1:0]         identity_ratio,
  output logic [btp_pkg::DEVR_W-1:0]        deviation_ratio
);

  localparam int unsigned NW    = $clog2(SAMPLE_LIMIT + 1);
  localparam int unsigned TOT_W = NW + 3;
  localparam logic [btp_pkg::LEN_W-1:0] LIMIT = btp_pkg::LEN_W'(SAMPLE_LIMIT);

  // Region accumulators.
  logic [7:0]                  prev_byte;
  logic [btp_pkg::LEN_W-1:0]   bytes_seen;
  logic [btp_pkg::ID_W-1:0]    id_tally;
  logic [btp_pkg::DEV_W-1:0]   dev_tally;

  // Snapshot of a finished region.
  logic [btp_pkg::ADDR_W-1:0]  snap_addr;
  logic [btp_pkg::LEN_W-1:0]   snap_len;
  logic [btp_pkg::ID_W-1:0]    snap_id;
  logic [btp_pkg::DEV_W-1:0]   snap_dev;
  logic [NW-1:0]               snap_n;
  logic [TOT_W-1:0]            total;

  // Two restoring division lanes sharing one step counter.
  logic [btp_pkg::DVD_W-1:0]   dvd_id;
  logic [btp_pkg::DVD_W-1:0]   dvd_dev;
  logic [TOT_W-1:0]            rem_id;
  logic [TOT_W-1:0]            rem_dev;
  logic [btp_pkg::QUO_W-1:0]   quo_id;
  logic [btp_pkg::QUO_W-1:0]   quo_dev;
  logic [btp_pkg::CNT_W-1:0]   step_cnt;

  btp_pkg::score_t             score;
  logic                        in_window;
  logic                        do_tally;
  logic [btp_pkg::ID_W:0]      id_sum;
  logic [btp_pkg::DEV_W:0]     dev_sum;
  logic [btp_pkg::ID_W-1:0]    id_upd;
  logic [btp_pkg::DEV_W-1:0]   dev_upd;
  logic [btp_pkg::LEN_W-1:0]   len_upd;
  logic [NW-1:0]               n_upd;
  logic [TOT_W-1:0]            total_calc;
  logic [TOT_W:0]              rsh_id;
  logic [TOT_W:0]              rsh_dev;
  logic                        ge_id;
  logic                        ge_dev;

  always_comb begin
    score     = btp_pkg::pair_score(prev_byte, data_byte);
    in_window = bytes_seen < LIMIT;
    do_tally  = (bytes_seen != '0) && in_window;
    id_sum    = {1'b0, id_tally} + (btp_pkg::ID_W + 1)'(score.ids);
    dev_sum   = {1'b0, dev_tally} + (btp_pkg::DEV_W + 1)'(score.dev);
    id_upd    = id_tally;
    dev_upd   = dev_tally;
    if (do_tally) begin
      id_upd  = (id_sum > (btp_pkg::ID_W + 1)'(btp_pkg::ID_MAX)) ?
                btp_pkg::ID_MAX : id_sum[btp_pkg::ID_W-1:0];
      dev_upd = dev_sum[btp_pkg::DEV_W] ? btp_pkg::DEV_MAX : dev_sum[btp_pkg::DEV_W-1:0];
    end
    len_upd = (bytes_seen == btp_pkg::LEN_MAX) ? bytes_seen : bytes_seen + 1'b1;
    // Count of sampled bytes including this one; never exceeds the limit.
    n_upd   = in_window ? NW'(bytes_seen) + 1'b1 : NW'(SAMPLE_LIMIT);

    total_calc = (snap_n >= NW'(2)) ? {snap_n - 1'b1, 3'b000} : '0;

    rsh_id  = {rem_id, dvd_id[btp_pkg::DVD_W-1]};
    rsh_dev = {rem_dev, dvd_dev[btp_pkg::DVD_W-1]};
    ge_id   = rsh_id >= {1'b0, total};
    ge_dev  = rsh_dev >= {1'b0, total};

    status.div_last = step_cnt == btp_pkg::CNT_W'(btp_pkg::DVD_W - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte  <= '0;
      bytes_seen <= '0;
      id_tally   <= '0;
      dev_tally  <= '0;
    end else if (cmd.accept) begin
      if (last_byte) begin
        prev_byte  <= '0;
        bytes_seen <= '0;
        id_tally   <= '0;
        dev_tally  <= '0;
      end else begin
        prev_byte  <= data_byte;
        bytes_seen <= len_upd;
        id_tally   <= id_upd;
        dev_tally  <= dev_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && last_byte) begin
      snap_addr <= region_address;
      snap_len  <= len_upd;
      snap_id   <= id_upd;
      snap_dev  <= dev_upd;
      snap_n    <= n_upd;
    end

    if (cmd.prep) begin
      total    <= total_calc;
      dvd_id   <= {2'b00, snap_id, btp_pkg::FRAC_W'(0)} +
                  btp_pkg::DVD_W'(total_calc >> 1);
      dvd_dev  <= {1'b0, snap_dev, btp_pkg::FRAC_W'(0)} +
                  btp_pkg::DVD_W'(total_calc >> 1);
      rem_id   <= '0;
      rem_dev  <= '0;
      quo_id   <= '0;
      quo_dev  <= '0;
      step_cnt <= '0;
    end else if (cmd.step) begin
      dvd_id   <= dvd_id << 1;
      dvd_dev  <= dvd_dev << 1;
      rem_id   <= ge_id ? TOT_W'(rsh_id - {1'b0, total}) : rsh_id[TOT_W-1:0];
      rem_dev  <= ge_dev ? TOT_W'(rsh_dev - {1'b0, total}) : rsh_dev[TOT_W-1:0];
      quo_id   <= {quo_id[btp_pkg::QUO_W-2:0], ge_id};
      quo_dev  <= {quo_dev[btp_pkg::QUO_W-2:0], ge_dev};
      step_cnt <= step_cnt + 1'b1;
    end

    if (cmd.load) begin
      out_address    <= snap_addr;
      region_length  <= snap_len;
      identity_count <= snap_id;
      deviation_sum  <= snap_dev;
      // A region of fewer than two bytes has no tokens and reports zero ratios.
      if (total == '0) begin
        identity_ratio  <= '0;
        deviation_ratio <= '0;
      end else begin
        identity_ratio  <= quo_id[btp_pkg::IDR_W-1:0];
        deviation_ratio <= quo_dev[btp_pkg::DEVR_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/byte_transition_profiler.sv
`default_nettype none

// Byte transition profiler. Bytes of a region arrive one per transaction, at
// up to one per clock, and each adjacent pair within the first SAMPLE_LIMIT
// bytes adds its eight tokens to the identity and deviation tallies. The
// transaction that carries last_byte closes the region: after a setup state,
// a bit-serial restoring divider produces both ratios in parallel at one
// quotient bit per cycle over a 33-bit dividend, and a finish state then
// moves the result into the output register, waiting while the previous
// result has not yet been taken. The input is closed from the closing
// transaction until that move. The input stays open while a result waits
// in the output register.
module byte_transition_profiler #(
  parameter int unsigned SAMPLE_LIMIT = 4096
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [7:0]                        data_byte,
  input  wire                               last_byte,
  input  wire  [btp_pkg::ADDR_W-1:0]        region_address,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [btp_pkg::ADDR_W-1:0]        out_address,
  output logic [btp_pkg::LEN_W-1:0]         region_length,
  output logic [btp_pkg::ID_W-1:0]          identity_count,
  output logic [btp_pkg::DEV_W-1:0]         deviation_sum,
  output logic [btp_pkg::IDR_W-1:0]         identity_ratio,
  output logic [btp_pkg::DEVR_W-1:0]        deviation_ratio
);

  btp_pkg::cmd_t    cmd;
  btp_pkg::status_t status;

  btp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  btp_datapath #(
    .SAMPLE_LIMIT (SAMPLE_LIMIT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .region_address  (region_address),
    .out_address     (out_address),
    .region_length   (region_length),
    .identity_count  (identity_count),
    .deviation_sum   (deviation_sum),
    .identity_ratio  (identity_ratio),
    .deviation_ratio (deviation_ratio)
  );

  // Closing a region blocks the input until its result is formed.
  a_close_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> !in_ready)
    else $error("input open right after a region was closed");

  a_density_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (identity_ratio <= btp_pkg::IDR_W'(65536)))
    else $error("identity_ratio above 1.0");

  a_energy_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (deviation_ratio <= btp_pkg::DEVR_W'(131072)))
    else $error("deviation_ratio above 2.0");

  a_short_region: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (region_length < btp_pkg::LEN_W'(2))) |->
      (identity_count == '0 && deviation_sum == '0 &&
       identity_ratio == '0 && deviation_ratio == '0))
    else $error("short region reported nonzero tallies");

endmodule

`default_nettype wire
